>>> design/hjct_pkg.sv
package hjct_pkg;

  localparam int unsigned NUM_SLOTS_DEFAULT = 256;

  localparam int unsigned OWN_W    = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned GEN_W    = 32;
  localparam int unsigned OUTST_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned FREED_W  = 9;

  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERRUN   = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [OWN_W-1:0]   own_id;
    logic               attach;
    logic [COUNT_W-1:0] launch_count;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_id;
    logic [GEN_W-1:0]    slot_gen;
    logic [FREED_W-1:0]  freed_count;
  } rsp_t;

endpackage

>>> design/hjct_if.sv
interface hjct_req_if;
  logic             valid;
  logic             ready;
  hjct_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hjct_rsp_if;
  logic             valid;
  logic             ready;
  hjct_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/hjct_ram.sv
module hjct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/hierarchical_job_completion_tracker.sv
// allocate: PRD, PWR (parent link only), HRD, HWR, DONE; with no free slot straight to DONE
// finish: FRD, FWR per slot on the parent chain, then FRD, DONE; bounded by the table size
// one request at a time; the next request is taken while a result waits in the output register
// the slot table (one read port, one write port) and the shared 32-bit adder set this order
// reset: asynchronous, then a clearing pass over every slot before the first request
module hierarchical_job_completion_tracker #(
  parameter int unsigned NumSlots = hjct_pkg::NUM_SLOTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hjct_req_if.sink    req_i,
  hjct_rsp_if.source  rsp_o
);

  localparam int unsigned IW = $clog2(NumSlots);
  localparam int unsigned LW = $clog2(NumSlots + 1);
  localparam int unsigned GW = hjct_pkg::GEN_W;
  localparam int unsigned OW = hjct_pkg::OUTST_W;
  localparam int unsigned WW = GW + LW + OW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PWR   = 4'd3;
  localparam logic [3:0] S_HRD   = 4'd4;
  localparam logic [3:0] S_HWR   = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                         state_q, state_d;
  logic [IW-1:0]                      clr_q, clr_d;
  logic [LW-1:0]                      head_q, head_d;
  logic [LW-1:0]                      cur_q, cur_d;
  logic [LW-1:0]                      visit_q, visit_d;
  logic [hjct_pkg::FREED_W-1:0]       freed_q, freed_d;
  logic                               under_q, under_d;
  logic                               par_q, par_d;
  logic [hjct_pkg::OWN_W-1:0]         own_q, own_d;
  logic [hjct_pkg::COUNT_W-1:0]       count_q, count_d;
  logic [hjct_pkg::STATUS_W-1:0]      status_q, status_d;
  logic [hjct_pkg::SLOT_W-1:0]        id_q, id_d;
  logic [GW-1:0]                      gen_q, gen_d;
  hjct_pkg::rsp_t                     rsp_q, rsp_d;
  logic                               rsp_valid_q, rsp_valid_d;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic [GW-1:0] rd_gen;
  logic [LW-1:0] rd_link;
  logic [OW-1:0] rd_out;
  logic [OW-1:0] add_a, add_b, add_y;
  logic          req_acc;
  logic          own_ok;
  logic          head_ok;
  logic          cur_ok;
  logic [LW-1:0] term;

  hjct_ram #(
    .Width (WW),
    .Depth (NumSlots)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_gen  = rdata[WW-1 -: GW];
  assign rd_link = rdata[OW +: LW];
  assign rd_out  = rdata[0 +: OW];

  assign term    = LW'(NumSlots);
  assign own_ok  = 32'(req_i.data.own_id) < 32'(NumSlots);
  assign head_ok = head_q < term;
  assign cur_ok  = cur_q < term;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // shared adder: parent add, generation bump, count decrement
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_q)
      S_PWR: begin
        add_a = rd_out;
        add_b = OW'(count_q);
      end
      S_HWR: begin
        add_a = rd_gen;
        add_b = OW'(1);
      end
      S_FWR: begin
        add_a = rd_out;
        add_b = '1;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_y = add_a + add_b;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    head_d      = head_q;
    cur_d       = cur_q;
    visit_d     = visit_q;
    freed_d     = freed_q;
    under_d     = under_q;
    par_d       = par_q;
    own_d       = own_q;
    count_d     = count_q;
    status_d    = status_q;
    id_d        = id_q;
    gen_d       = gen_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = {GW'(0), LW'(clr_q) + LW'(1), OW'(0)};
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(NumSlots - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          own_d    = req_i.data.own_id;
          count_d  = req_i.data.launch_count;
          par_d    = req_i.data.attach && own_ok;
          status_d = hjct_pkg::STATUS_OK;
          id_d     = '0;
          gen_d    = '0;
          freed_d  = '0;
          under_d  = 1'b0;
          visit_d  = '0;
          cur_d    = own_ok ? LW'(req_i.data.own_id) : term;
          if (req_i.data.cmd == hjct_pkg::CMD_FINISH) begin
            state_d = S_FRD;
          end else if (!head_ok) begin
            status_d = hjct_pkg::STATUS_NO_FREE;
            state_d  = S_DONE;
          end else if (req_i.data.attach && own_ok) begin
            state_d = S_PRD;
          end else begin
            state_d = S_HRD;
          end
        end
      end
      S_PRD: begin
        raddr   = IW'(own_q);
        state_d = S_PWR;
      end
      S_PWR: begin
        we      = 1'b1;
        waddr   = IW'(own_q);
        wdata   = {rd_gen, rd_link, add_y};
        state_d = S_HRD;
      end
      S_HRD: begin
        raddr   = IW'(head_q);
        state_d = S_HWR;
      end
      S_HWR: begin
        we      = 1'b1;
        waddr   = IW'(head_q);
        wdata   = {add_y, par_q ? LW'(own_q) : term, OW'(count_q)};
        head_d  = rd_link;
        id_d    = hjct_pkg::SLOT_W'(head_q);
        gen_d   = add_y;
        state_d = S_DONE;
      end
      S_FRD: begin
        if (!cur_ok) begin
          status_d = under_q ? hjct_pkg::STATUS_UNDERFLOW : hjct_pkg::STATUS_OK;
          state_d  = S_DONE;
        end else if (visit_q == term) begin
          status_d = hjct_pkg::STATUS_OVERRUN;
          state_d  = S_DONE;
        end else begin
          raddr   = IW'(cur_q);
          visit_d = visit_q + LW'(1);
          state_d = S_FWR;
        end
      end
      S_FWR: begin
        cur_d   = rd_link;
        state_d = S_FRD;
        if (rd_out == '0) begin
          under_d = 1'b1;
        end else begin
          we    = 1'b1;
          waddr = IW'(cur_q);
          wdata = {rd_gen, (rd_out == OW'(1)) ? head_q : rd_link, add_y};
          if (rd_out == OW'(1)) begin
            head_d  = cur_q;
            freed_d = freed_q + hjct_pkg::FREED_W'(1);
          end
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_d.status      = status_q;
          rsp_d.slot_id     = id_q;
          rsp_d.slot_gen    = gen_q;
          rsp_d.freed_count = freed_q;
          rsp_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    visit_q  <= visit_d;
    freed_q  <= freed_d;
    under_q  <= under_d;
    par_q    <= par_d;
    own_q    <= own_d;
    count_q  <= count_d;
    status_q <= status_d;
    id_q     <= id_d;
    gen_q    <= gen_d;
    rsp_q    <= rsp_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

`ifndef ASSERT_OFF
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= term)
    else $error("free head out of range");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    visit_q <= term || state_q == S_IDLE || state_q == S_CLEAR)
    else $error("walk counter past table size");

  a_push_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FWR && rd_out == OW'(1)) |=> head_q == $past(cur_q))
    else $error("freed slot not pushed on free list");

  a_no_free_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.status == hjct_pkg::STATUS_NO_FREE) |->
      (rsp_q.slot_gen == '0 && rsp_q.slot_id == '0))
    else $error("failed allocate returned a slot");
`endif

endmodule
